@@ rtl/core/ddsp_pkg.sv @@
// Shared types and constants of the differential drive step pulse generator.
// Used by the top level and by the iterative divider; depends on nothing.
package ddsp_pkg;

   localparam int DVD_W      = 33;
   localparam int DVS_W      = 18;
   localparam int DIV_CNT_W  = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam int MUL_A_W    = 30;
   localparam int MUL_B_W    = 31;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int REC_SHIFT  = 37;
   localparam int RATE_W     = PROD_W - REC_SHIFT;

   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_MOTION  = 2'd1;
   localparam logic [1:0] OP_ENABLE  = 2'd2;
   localparam logic [1:0] OP_DISABLE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_M  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RATE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RATE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_LEVEL = 3'd4;

   // Rounded-up 2^37 / 125, exact floor division for dividends below 2^30.
   localparam logic [MUL_B_W-1:0] RECIP_125 = 31'd1099511628;

endpackage

@@ rtl/core/ddsp_div.sv @@
// Restoring unsigned divider that resolves one quotient bit per cycle.
// Depends on ddsp_pkg for the dividend, divisor and counter widths.
module ddsp_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ddsp_pkg::DVD_W-1:0]  dividend,
   input  logic [ddsp_pkg::DVS_W-1:0]  divisor,
   output logic                        done,
   output logic [ddsp_pkg::DVD_W-1:0]  quotient
);
   import ddsp_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DVS_W:0]       shifted;
   logic [DVS_W:0]       trial;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DVD_W - 1);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (!trial[DVS_W]) begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/core/diff_drive_step_pulse_generator.sv @@
// Ticks, enable, disable and ignored motion requests give a response the cycle after
// acceptance, and one such request is taken per cycle while responses drain.
// A motion request on an enabled drive scales the turn rate, then per wheel forms the step rate
// and, if the wheel runs at a nonzero clamped rate, the half period on the bit-serial divider.
// Synchronous active-high reset: control and CSR registers to defaults, drive disabled, both wheels stopped.
// Top level; instantiates ddsp_div and depends on ddsp_pkg.
module diff_drive_step_pulse_generator #(
   parameter int PERIOD_WIDTH     = 19,
   parameter int TICKS_PER_SECOND = 1000000
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_opcode,
   input  logic signed [15:0]                   req_linear_velocity,
   input  logic signed [15:0]                   req_angular_velocity,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_left_step,
   output logic                                 rsp_left_dir,
   output logic                                 rsp_right_step,
   output logic                                 rsp_right_dir,
   output logic                                 rsp_driver_enable_pin,
   output logic                                 rsp_is_enabled,
   input  logic                                 csr_we,
   input  logic [ddsp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ddsp_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ddsp_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b00000001,
      S_MUL_D  = 8'b00000010,
      S_REC_D  = 8'b00000100,
      S_SET_D  = 8'b00001000,
      S_MUL_V  = 8'b00010000,
      S_REC_V  = 8'b00100000,
      S_RATE   = 8'b01000000,
      S_DIV_HP = 8'b10000000
   } seq_state_type;

   localparam logic [PERIOD_WIDTH-1:0] HP_MASK  = {PERIOD_WIDTH{1'b1}};
   localparam logic [PERIOD_WIDTH-1:0] HP_RESET = PERIOD_WIDTH'(1000);

   seq_state_type state_ff, state_in;
   logic          whl_ff, whl_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          drive_on_ff, drive_on_in;
   logic [1:0]    tog_ff, tog_in;
   logic [1:0]    pin_ff, pin_in;
   logic [1:0]    dir_ff, dir_in;
   logic [1:0]    run_ff, run_in;
   logic [PERIOD_WIDTH-1:0] hp_ff [2];
   logic [PERIOD_WIDTH-1:0] hp_in [2];
   logic [PERIOD_WIDTH-1:0] cnt_ff [2];
   logic [PERIOD_WIDTH-1:0] cnt_in [2];

   logic signed [15:0] lin_ff, lin_in;
   logic signed [15:0] ang_ff, ang_in;
   logic [17:0]        d_ff, d_in;
   logic               vneg_ff, vneg_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   logic [11:0] tw_ff, tw_in;
   logic [15:0] spm_ff, spm_in;
   logic [9:0]  minr_ff, minr_in;
   logic [16:0] maxr_ff, maxr_in;
   logic        eal_ff, eal_in;

   logic               req_fire;
   logic [16:0]        ang_ext, ang_mag;
   logic [18:0]        v_sum, v_neg_val;
   logic [16:0]        v_mag;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [17:0]        d_mag;
   logic [RATE_W-1:0]  rate_q;
   logic               div_start, div_done;
   logic [DVD_W-1:0]   div_dividend, div_quo;
   logic [DVS_W-1:0]   div_divisor;
   logic               below_min;
   logic [16:0]        rate_clamped;
   logic [PERIOD_WIDTH-1:0] hp_sat;
   logic [PERIOD_WIDTH:0]   cnt_next [2];

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   assign ang_ext   = {ang_ff[15], ang_ff};
   assign ang_mag   = ang_ff[15] ? (17'd0 - ang_ext) : ang_ext;
   assign v_sum     = whl_ff ? ({{3{lin_ff[15]}}, lin_ff} + {d_ff[17], d_ff})
                             : ({{3{lin_ff[15]}}, lin_ff} - {d_ff[17], d_ff});
   assign v_neg_val = 19'd0 - v_sum;
   assign v_mag     = v_sum[18] ? v_neg_val[16:0] : v_sum[16:0];

   // Division by 2000 is a shift by four and by 1000 a shift by three, each followed by
   // a reciprocal multiply by 1/125 on the same multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MUL_D: begin
            mul_a = {13'd0, ang_mag};
            mul_b = {19'd0, tw_ff};
         end
         S_REC_D: begin
            mul_a = prod_ff[4 +: MUL_A_W];
            mul_b = RECIP_125;
         end
         S_MUL_V: begin
            mul_a = {13'd0, v_mag};
            mul_b = {15'd0, spm_ff};
         end
         S_REC_V: begin
            mul_a = prod_ff[3 +: MUL_A_W];
            mul_b = RECIP_125;
         end
         default: begin
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign d_mag   = prod_ff[REC_SHIFT +: 18];
   assign rate_q  = prod_ff[PROD_W-1:REC_SHIFT];

   assign below_min    = rate_q < RATE_W'(minr_ff);
   assign rate_clamped = (rate_q > RATE_W'(maxr_ff)) ? maxr_ff : rate_q[16:0];
   assign hp_sat       = ((div_quo >> PERIOD_WIDTH) != '0) ? HP_MASK
                                                           : div_quo[PERIOD_WIDTH-1:0];

   assign div_dividend = DVD_W'(TICKS_PER_SECOND);
   assign div_divisor  = {rate_clamped, 1'b0};

   ddsp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         cnt_next[i] = {1'b0, cnt_ff[i]} + 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      whl_in       = whl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      drive_on_in  = drive_on_ff;
      tog_in       = tog_ff;
      pin_in       = pin_ff;
      dir_in       = dir_ff;
      run_in       = run_ff;
      hp_in        = hp_ff;
      cnt_in       = cnt_ff;
      lin_in       = lin_ff;
      ang_in       = ang_ff;
      d_in         = d_ff;
      vneg_in      = vneg_ff;
      div_start    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_opcode)
                  OP_TICK: begin
                     for (int i = 0; i < 2; i++) begin
                        if (run_ff[i]) begin
                           if (cnt_next[i] >= {1'b0, hp_ff[i]}) begin
                              tog_in[i] = !tog_ff[i];
                              pin_in[i] = !tog_ff[i];
                              cnt_in[i] = '0;
                           end else begin
                              cnt_in[i] = cnt_next[i][PERIOD_WIDTH-1:0];
                           end
                        end
                     end
                     rsp_valid_in = 1'b1;
                  end
                  OP_MOTION: begin
                     if (drive_on_ff) begin
                        lin_in   = req_linear_velocity;
                        ang_in   = req_angular_velocity;
                        state_in = S_MUL_D;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_ENABLE: begin
                     drive_on_in  = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     drive_on_in  = 1'b0;
                     run_in       = '0;
                     pin_in       = '0;
                     tog_in       = '0;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_MUL_D: begin
            whl_in   = 1'b0;
            state_in = S_REC_D;
         end
         S_REC_D: begin
            state_in = S_SET_D;
         end
         S_SET_D: begin
            d_in     = ang_ff[15] ? (18'd0 - d_mag) : d_mag;
            state_in = S_MUL_V;
         end
         S_MUL_V: begin
            vneg_in  = v_sum[18];
            state_in = S_REC_V;
         end
         S_REC_V: begin
            state_in = S_RATE;
         end
         S_RATE: begin
            if (below_min) begin
               run_in[whl_ff] = 1'b0;
               pin_in[whl_ff] = 1'b0;
            end else begin
               dir_in[whl_ff] = !vneg_ff;
               if (rate_clamped == '0) begin
                  hp_in[whl_ff]  = HP_MASK;
                  run_in[whl_ff] = 1'b1;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV_HP;
               end
            end
            if (below_min || rate_clamped == '0) begin
               if (!whl_ff) begin
                  whl_in   = 1'b1;
                  state_in = S_MUL_V;
               end else begin
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_DIV_HP: begin
            if (div_done) begin
               hp_in[whl_ff]  = hp_sat;
               run_in[whl_ff] = 1'b1;
               if (!whl_ff) begin
                  whl_in   = 1'b1;
                  state_in = S_MUL_V;
               end else begin
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      tw_in   = tw_ff;
      spm_in  = spm_ff;
      minr_in = minr_ff;
      maxr_in = maxr_ff;
      eal_in  = eal_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TRACK_WIDTH:  tw_in   = csr_wdata[11:0];
            CSR_STEPS_PER_M:  spm_in  = csr_wdata[15:0];
            CSR_MIN_RATE:     minr_in = csr_wdata[9:0];
            CSR_MAX_RATE:     maxr_in = csr_wdata[16:0];
            CSR_ENABLE_LEVEL: eal_in  = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         whl_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         drive_on_ff  <= 1'b0;
         tog_ff       <= '0;
         pin_ff       <= '0;
         dir_ff       <= '0;
         run_ff       <= '0;
         for (int i = 0; i < 2; i++) begin
            hp_ff[i]  <= HP_RESET;
            cnt_ff[i] <= '0;
         end
         tw_ff        <= 12'd300;
         spm_ff       <= 16'd8000;
         minr_ff      <= 10'd10;
         maxr_ff      <= 17'd20000;
         eal_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         whl_ff       <= whl_in;
         rsp_valid_ff <= rsp_valid_in;
         drive_on_ff  <= drive_on_in;
         tog_ff       <= tog_in;
         pin_ff       <= pin_in;
         dir_ff       <= dir_in;
         run_ff       <= run_in;
         hp_ff        <= hp_in;
         cnt_ff       <= cnt_in;
         tw_ff        <= tw_in;
         spm_ff       <= spm_in;
         minr_ff      <= minr_in;
         maxr_ff      <= maxr_in;
         eal_ff       <= eal_in;
      end
      lin_ff  <= lin_in;
      ang_ff  <= ang_in;
      d_ff    <= d_in;
      vneg_ff <= vneg_in;
      prod_ff <= prod_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_left_step         = pin_ff[0];
   assign rsp_left_dir          = dir_ff[0];
   assign rsp_right_step        = pin_ff[1];
   assign rsp_right_dir         = dir_ff[1];
   assign rsp_driver_enable_pin = drive_on_ff ? eal_ff : !eal_ff;
   assign rsp_is_enabled        = drive_on_ff;

`ifndef NO_ASSERTIONS
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready)
      else $error("Request taken while a motion update is in progress.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (!rsp_valid_ff || rsp_ready))
      else $error("Request taken while an earlier response is still pending.");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_HP))
      else $error("Divider finished outside the division state.");

   a_disabled_stopped: assert property (@(posedge clock) disable iff (reset)
      !drive_on_ff |-> (run_ff == 2'b00))
      else $error("A wheel runs while the drive is disabled.");

   a_stopped_pin_low: assert property (@(posedge clock) disable iff (reset)
      ((pin_ff & ~run_ff) == 2'b00))
      else $error("Step pin high on a stopped wheel.");
`endif

endmodule

@@ sim/tb_diff_drive_step_pulse_generator.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for diff_drive_step_pulse_generator: random and directed requests
// are checked against a pin-level predictor kept in a small scoreboard class.
// Depends on ddsp_pkg and the RTL of the block.
module tb_diff_drive_step_pulse_generator;
   import ddsp_pkg::*;

   localparam int PERIOD_W = 19;
   localparam int TICKS_PER_S = 1000000;
   localparam longint unsigned PERIOD_MASK = (64'd1 << PERIOD_W) - 1;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic left_step;
      logic left_dir;
      logic right_step;
      logic right_dir;
      logic enable_pin;
      logic is_enabled;
   } pin_levels_type;

   typedef struct {
      bit toggle;
      bit pin;
      bit dir;
      bit running;
      bit [PERIOD_W-1:0] half_period;
      bit [PERIOD_W-1:0] count;
   } wheel_state_type;

   class step_pin_predictor;
      pin_levels_type pending_pins[$];
      int mismatch_count;
      bit [11:0] track_mm;
      bit [15:0] steps_per_m;
      bit [9:0] min_rate;
      bit [16:0] max_rate;
      bit active_level;
      bit drive_on;
      wheel_state_type left_wheel;
      wheel_state_type right_wheel;

      function new();
         track_mm = 12'd300;
         steps_per_m = 16'd8000;
         min_rate = 10'd10;
         max_rate = 17'd20000;
         active_level = 1'b0;
         drive_on = 1'b0;
         left_wheel = '{toggle: 0, pin: 0, dir: 0, running: 0, half_period: 1000, count: 0};
         right_wheel = left_wheel;
         mismatch_count = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_TRACK_WIDTH: track_mm = val[11:0];
            CSR_STEPS_PER_M: steps_per_m = val[15:0];
            CSR_MIN_RATE: min_rate = val[9:0];
            CSR_MAX_RATE: max_rate = val[16:0];
            CSR_ENABLE_LEVEL: active_level = val[0];
            default: ;
         endcase
      endfunction

      function wheel_state_type set_speed(wheel_state_type w, longint v);
         longint unsigned mag;
         longint unsigned rate;
         longint unsigned hp;
         mag = (v < 0) ? -v : v;
         rate = mag * steps_per_m / 1000;
         if (rate < min_rate) begin
            w.running = 1'b0;
            w.pin = 1'b0;
            return w;
         end
         w.dir = (v >= 0);
         if (rate > max_rate) rate = max_rate;
         if (rate == 0) hp = PERIOD_MASK;
         else hp = TICKS_PER_S / (2 * rate);
         if (hp > PERIOD_MASK) hp = PERIOD_MASK;
         w.half_period = hp[PERIOD_W-1:0];
         w.running = 1'b1;
         return w;
      endfunction

      function wheel_state_type tick_wheel(wheel_state_type w);
         longint unsigned advanced;
         if (!w.running) return w;
         advanced = w.count + 1;
         if (advanced >= w.half_period) begin
            w.toggle = !w.toggle;
            w.pin = w.toggle;
            w.count = '0;
         end else begin
            w.count = advanced[PERIOD_W-1:0];
         end
         return w;
      endfunction

      function void take_request(logic [1:0] op, logic [15:0] lin, logic [15:0] ang);
         longint lin_v;
         longint ang_v;
         longint d;
         pin_levels_type want;
         case (op)
            OP_TICK: begin
               left_wheel = tick_wheel(left_wheel);
               right_wheel = tick_wheel(right_wheel);
            end
            OP_MOTION: begin
               if (drive_on) begin
                  lin_v = longint'($signed(lin));
                  ang_v = longint'($signed(ang));
                  d = ang_v * longint'(track_mm) / 2000;
                  left_wheel = set_speed(left_wheel, lin_v - d);
                  right_wheel = set_speed(right_wheel, lin_v + d);
               end
            end
            OP_ENABLE: drive_on = 1'b1;
            default: begin
               left_wheel.running = 1'b0;
               right_wheel.running = 1'b0;
               left_wheel.pin = 1'b0;
               right_wheel.pin = 1'b0;
               left_wheel.toggle = 1'b0;
               right_wheel.toggle = 1'b0;
               drive_on = 1'b0;
            end
         endcase
         want.left_step = left_wheel.pin;
         want.left_dir = left_wheel.dir;
         want.right_step = right_wheel.pin;
         want.right_dir = right_wheel.dir;
         want.enable_pin = drive_on ? active_level : !active_level;
         want.is_enabled = drive_on;
         pending_pins.push_back(want);
      endfunction

      task report_mismatch(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         mismatch_count++;
      endtask

      task compare_pin(string name, logic got, logic want);
         if (got !== want)
            report_mismatch($sformatf("%s got %b expected %b", name, got, want));
      endtask

      task check_pins(pin_levels_type got);
         pin_levels_type want;
         if (pending_pins.size() == 0) begin
            report_mismatch("response with no request pending");
            return;
         end
         want = pending_pins.pop_front();
         compare_pin("left_step", got.left_step, want.left_step);
         compare_pin("left_dir", got.left_dir, want.left_dir);
         compare_pin("right_step", got.right_step, want.right_step);
         compare_pin("right_dir", got.right_dir, want.right_dir);
         compare_pin("driver_enable_pin", got.enable_pin, want.enable_pin);
         compare_pin("is_enabled", got.is_enabled, want.is_enabled);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_opcode;
   logic signed [15:0] req_linear_velocity;
   logic signed [15:0] req_angular_velocity;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_left_step;
   logic rsp_left_dir;
   logic rsp_right_step;
   logic rsp_right_dir;
   logic rsp_driver_enable_pin;
   logic rsp_is_enabled;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   step_pin_predictor board;
   bit req_quiet;
   bit rsp_quiet;
   int idle_cycles = 0;

   diff_drive_step_pulse_generator #(
      .PERIOD_WIDTH(PERIOD_W),
      .TICKS_PER_SECOND(TICKS_PER_S)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_linear_velocity(req_linear_velocity),
      .req_angular_velocity(req_angular_velocity),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_left_step(rsp_left_step),
      .rsp_left_dir(rsp_left_dir),
      .rsp_right_step(rsp_right_step),
      .rsp_right_dir(rsp_right_dir),
      .rsp_driver_enable_pin(rsp_driver_enable_pin),
      .rsp_is_enabled(rsp_is_enabled),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_diff_drive_step_pulse_generator NOT OK");
         $finish;
      end
   end

   task automatic send_request(input logic [1:0] op, input logic [15:0] lin,
                               input logic [15:0] ang);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_linear_velocity <= lin;
      req_angular_velocity <= ang;
      do @(posedge clock); while (!req_ready);
      board.take_request(op, lin, ang);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending_pins.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.write_reg(idx, val);
   endtask

   task automatic program_drive(input int track, input int spm, input int min_r,
                                input int max_r, input int level);
      write_csr(CSR_TRACK_WIDTH, CSR_DATA_W'(track));
      write_csr(CSR_STEPS_PER_M, CSR_DATA_W'(spm));
      write_csr(CSR_MIN_RATE, CSR_DATA_W'(min_r));
      write_csr(CSR_MAX_RATE, CSR_DATA_W'(max_r));
      write_csr(CSR_ENABLE_LEVEL, CSR_DATA_W'(level));
      csr_we <= 1'b0;
   endtask

   function automatic logic [1:0] draw_opcode();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return OP_TICK;
      if (pick < 90) return OP_MOTION;
      if (pick < 96) return OP_ENABLE;
      return OP_DISABLE;
   endfunction

   function automatic logic [15:0] draw_speed();
      case ($urandom_range(0, 2))
         0: return 16'($urandom());
         1: return 16'($urandom_range(0, 400) - 200);
         default: return 16'($urandom_range(0, 6000) - 3000);
      endcase
   endfunction

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            req_quiet = ($urandom_range(0, 2) == 0);
            rsp_quiet = ($urandom_range(0, 2) == 0);
         end
         send_request(draw_opcode(), draw_speed(), draw_speed());
      end
      settle();
   endtask

   initial begin
      pin_levels_type seen;
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = rsp_quiet ? 0 : $urandom_range(0, 10);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         seen = {rsp_left_step, rsp_left_dir, rsp_right_step, rsp_right_dir,
                 rsp_driver_enable_pin, rsp_is_enabled};
         board.check_pins(seen);
      end
   end

   initial begin
      board = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= OP_TICK;
      req_linear_velocity <= '0;
      req_angular_velocity <= '0;
      rsp_ready <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= CSR_TRACK_WIDTH;
      csr_wdata <= '0;
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Power-on settings: ignored motion, pauses below the minimum rate, clamping.
      send_request(OP_MOTION, 16'sd32767, -16'sd32768);
      send_request(OP_TICK, 16'hFFFF, 16'hFFFF);
      send_request(OP_ENABLE, 16'h0000, 16'h0000);
      send_request(OP_MOTION, 16'sd1000, 16'sd0);
      send_request(OP_TICK, 16'h0000, 16'h0000);
      send_request(OP_MOTION, -16'sd32768, 16'sd32767);
      send_request(OP_MOTION, 16'sd1, 16'sd0);
      send_request(OP_MOTION, 16'sd32767, -16'sd32768);
      send_request(OP_TICK, 16'h0000, 16'h0000);
      send_request(OP_DISABLE, 16'h0000, 16'h0000);
      send_request(OP_TICK, 16'h0000, 16'h0000);
      send_request(OP_ENABLE, 16'h0000, 16'h0000);
      send_request(OP_MOTION, 16'sd0, 16'sd0);
      settle();

      // Widest track and fastest stepping, so the step pins toggle every few ticks.
      program_drive(4095, 65535, 1, 131071, 1);
      send_request(OP_ENABLE, 16'h0000, 16'h0000);
      send_request(OP_MOTION, 16'sd32767, 16'sd32767);
      repeat (4) send_request(OP_TICK, 16'h0000, 16'h0000);
      send_request(OP_MOTION, -16'sd1, 16'sd0);
      send_request(OP_MOTION, 16'sd0, -16'sd1);
      send_request(OP_TICK, 16'h0000, 16'h0000);
      send_request(OP_DISABLE, 16'h0000, 16'h0000);
      settle();

      program_drive(1, 1, 1000, 1, 0);
      run_random(60);
      // Zero rate limits: the half period saturates.
      program_drive(4095, 65535, 0, 0, 1);
      run_random(60);
      program_drive(4095, 65535, 1, 100000, 0);
      run_random(170);
      repeat (4) begin
         program_drive($urandom_range(1, 4095), $urandom_range(1000, 65535),
                       $urandom_range(1, 1000), $urandom_range(10000, 100000),
                       $urandom_range(0, 1));
         run_random(165);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.pending_pins.size() != 0)
         board.report_mismatch("responses still outstanding at end of run");
      if (board.mismatch_count == 0) begin
         $display("tb_diff_drive_step_pulse_generator OK");
      end else begin
         $display("tb_diff_drive_step_pulse_generator NOT OK");
      end
      $finish;
   end
endmodule

@@ diff_drive_step_pulse_generator.f @@
rtl/core/ddsp_pkg.sv
rtl/core/ddsp_div.sv
rtl/core/diff_drive_step_pulse_generator.sv
sim/tb_diff_drive_step_pulse_generator.sv
